>>> hdl/bdmc_pkg.sv
// ----------------------------------------------------------------------------
// Buffered direct-mapped cache package
// Shared widths, codes and record types of the cache unit.
// ----------------------------------------------------------------------------
package bdmc_pkg;

  localparam int ADDR_W   = 24;
  localparam int DATA_W   = 64;
  localparam int STAMP_W  = 16;

  localparam int LINES_DEF        = 1024;
  localparam int VICTIM_DEPTH_DEF = 64;
  localparam int LOG_DEPTH_DEF    = 256;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_FILL   = 2'd2,
    OP_COMMIT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_LINE    = 3'd0,
    ST_RESERVE = 3'd1,
    ST_FETCH   = 3'd2,
    ST_RFULL   = 3'd3,
    ST_WB      = 3'd4,
    ST_NONE    = 3'd5,
    ST_FILLED  = 3'd6,
    ST_LFULL   = 3'd7
  } status_t;

  typedef struct packed {
    addr_t  addr;
    data_t  data;
    stamp_t stamp;
  } victim_t;

  typedef struct packed {
    logic  start;
    addr_t key;
  } vsrch_req_t;

  typedef struct packed {
    logic    done;
    logic    found;
    victim_t entry;
  } vsrch_rsp_t;

endpackage

>>> hdl/bdmc_ifs.sv
// ----------------------------------------------------------------------------
// Buffered direct-mapped cache channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface bdmc_req_if;
  logic           valid;
  logic           ready;
  bdmc_pkg::op_t  op;
  bdmc_pkg::addr_t address;
  bdmc_pkg::data_t write_data;

  modport source (output valid, op, address, write_data, input ready);
  modport sink (input valid, op, address, write_data, output ready);
endinterface

interface bdmc_rsp_if;
  logic              valid;
  logic              ready;
  bdmc_pkg::status_t status;
  bdmc_pkg::data_t   read_data;
  bdmc_pkg::addr_t   out_address;
  bdmc_pkg::stamp_t  stamp;
  logic              last;

  modport source (output valid, status, read_data, out_address, stamp, last, input ready);
  modport sink (input valid, status, read_data, out_address, stamp, last, output ready);
endinterface

>>> hdl/bdmc_victim_unit.sv
// ----------------------------------------------------------------------------
// Victim reserve and search unit
// Holds the victim reserve and scans it one entry at a time for a key.
// ----------------------------------------------------------------------------
module bdmc_victim_unit #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bdmc_pkg::vsrch_req_t req,
  input  logic [CNT_W-1:0]     count,
  input  logic                 we,
  input  logic [IDX_W-1:0]     widx,
  input  bdmc_pkg::victim_t    wentry,
  output bdmc_pkg::vsrch_rsp_t rsp,
  output logic [IDX_W-1:0]     idx
);
  import bdmc_pkg::*;

  typedef enum logic [1:0] {V_IDLE, V_RD, V_CMP} vstate_t;

  vstate_t          state;
  logic [CNT_W-1:0] pos;
  addr_t            key;
  logic             done;
  logic             found;
  victim_t          vmem [DEPTH];
  victim_t          vq;

  always_ff @(posedge clk) begin
    vq <= vmem[pos[IDX_W-1:0]];
    if (we) begin
      vmem[widx] <= wentry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= V_IDLE;
      done  <= 1'b0;
      found <= 1'b0;
      pos   <= '0;
    end else if (req.start) begin
      key   <= req.key;
      pos   <= '0;
      found <= 1'b0;
      if (count == '0) begin
        done  <= 1'b1;
        state <= V_IDLE;
      end else begin
        done  <= 1'b0;
        state <= V_RD;
      end
    end else begin
      case (state)
        V_RD: begin
          state <= V_CMP;
        end
        V_CMP: begin
          if (vq.addr == key) begin
            found <= 1'b1;
            done  <= 1'b1;
            state <= V_IDLE;
          end else if (pos + CNT_W'(1) == count) begin
            done  <= 1'b1;
            state <= V_IDLE;
          end else begin
            pos   <= pos + CNT_W'(1);
            state <= V_RD;
          end
        end
        default: begin
          state <= V_IDLE;
        end
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.found = found;
  assign rsp.entry = vq;
  assign idx       = pos[IDX_W-1:0];

endmodule

>>> hdl/buffered_direct_mapped_cache_unit.sv
// ----------------------------------------------------------------------------
// Buffered direct-mapped cache unit
// Direct-mapped cell cache with a victim reserve and a change log drained on commit.
// ----------------------------------------------------------------------------
// With no reserve search a request beat passes S_LREAD and S_LCHK, and the response
// beat is registered in S_FINISH; a commit step first reads the log in S_LOGRD, and an
// empty commit goes from S_LOGRD straight to S_FINISH. A reserve search adds S_SEARCH,
// which scans the reserve entries in turn. One request at a time; the next beat is
// taken in S_IDLE once the response is registered, later while the receiver stalls.
// Reset: synchronous; a clearing pass then clears every line, one line per cycle,
// before the first request beat is taken.
// ----------------------------------------------------------------------------
module buffered_direct_mapped_cache_unit #(
  parameter int LINES        = bdmc_pkg::LINES_DEF,
  parameter int VICTIM_DEPTH = bdmc_pkg::VICTIM_DEPTH_DEF,
  parameter int LOG_DEPTH    = bdmc_pkg::LOG_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bdmc_req_if.sink   req,
  bdmc_rsp_if.source rsp
);
  import bdmc_pkg::*;

  localparam int OFF_W  = $clog2(LINES);
  localparam int PAGE_W = ADDR_W - OFF_W;
  localparam int VCNT_W = $clog2(VICTIM_DEPTH + 1);
  localparam int VIDX_W = (VICTIM_DEPTH > 1) ? $clog2(VICTIM_DEPTH) : 1;
  localparam int LCNT_W = $clog2(LOG_DEPTH + 1);
  localparam int LIDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [PAGE_W-1:0] page;
    stamp_t            stamp;
    data_t             data;
  } line_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOGRD, S_LREAD, S_LCHK, S_SEARCH, S_FINISH
  } state_t;

  state_t            state;
  logic [OFF_W-1:0]  clr_idx;
  op_t               cur_op;
  addr_t             cur_addr;
  data_t             cur_data;
  logic              srch;
  logic              cmt_empty;
  logic [VCNT_W-1:0] victim_count;
  logic [LCNT_W-1:0] log_count;
  logic [LCNT_W-1:0] drain_index;
  stamp_t            write_counter;

  line_t             lmem [LINES];
  line_t             lq;
  addr_t             logm [LOG_DEPTH];
  addr_t             log_q;

  vsrch_req_t        vreq;
  vsrch_rsp_t        vr;
  logic [VIDX_W-1:0] vr_idx;

  logic [OFF_W-1:0]  cur_off;
  logic [PAGE_W-1:0] cur_pg;
  logic              hit;
  logic              conflict;
  logic              found;
  logic              need_srch;
  logic              vfull;
  logic              lfull;
  logic              out_free;
  stamp_t            wc_next;

  status_t           f_status;
  data_t             f_data;
  addr_t             f_addr;
  stamp_t            f_stamp;
  logic              f_last;
  logic              f_lwe;
  line_t             f_lword;
  logic              f_vwe;
  logic [VIDX_W-1:0] f_vidx;
  victim_t           f_ventry;
  logic              f_vinc;
  logic              f_logwe;
  logic              f_wcinc;
  logic              f_drain;
  logic              f_empty;

  logic              lwe;
  logic [OFF_W-1:0]  lw_idx;
  line_t             lw_word;
  logic              need_move;
  logic              need_log;

  assign cur_off   = cur_addr[OFF_W-1:0];
  assign cur_pg    = cur_addr[ADDR_W-1:OFF_W];
  assign hit       = lq.valid && (lq.page == cur_pg);
  assign conflict  = lq.valid && (lq.page != cur_pg);
  assign found     = srch && vr.found;
  assign vfull     = victim_count >= VCNT_W'(VICTIM_DEPTH);
  assign lfull     = log_count >= LCNT_W'(LOG_DEPTH);
  assign out_free  = !rsp.valid || rsp.ready;
  assign wc_next   = write_counter + STAMP_W'(1);
  assign req.ready = (state == S_IDLE);

  always_comb begin
    case (cur_op)
      OP_GET:    need_srch = !hit;
      OP_SET:    need_srch = conflict;
      OP_COMMIT: need_srch = !hit;
      default:   need_srch = 1'b0;
    endcase
  end

  always_comb begin
    f_status  = ST_NONE;
    f_data    = '0;
    f_addr    = cur_addr;
    f_stamp   = '0;
    f_last    = 1'b0;
    f_lwe     = 1'b0;
    f_lword   = lq;
    f_vwe     = 1'b0;
    f_vidx    = victim_count[VIDX_W-1:0];
    f_ventry  = '{addr: {lq.page, cur_off}, data: lq.data, stamp: lq.stamp};
    f_vinc    = 1'b0;
    f_logwe   = 1'b0;
    f_wcinc   = 1'b0;
    f_drain   = 1'b0;
    f_empty   = 1'b0;
    need_move = conflict && lq.dirty;
    need_log  = !(hit && lq.dirty);
    case (cur_op)
      OP_GET: begin
        if (hit) begin
          f_status = ST_LINE;
          f_data   = lq.data;
          f_stamp  = lq.stamp;
        end else if (found) begin
          f_status = ST_RESERVE;
          f_data   = vr.entry.data;
          f_stamp  = vr.entry.stamp;
        end else if (lq.valid && lq.dirty && vfull) begin
          f_status = ST_RFULL;
        end else begin
          f_vwe    = lq.valid && lq.dirty;
          f_vinc   = lq.valid && lq.dirty;
          f_lwe    = 1'b1;
          f_lword  = '{valid: 1'b1, dirty: 1'b0, page: cur_pg, stamp: write_counter,
                       data: '0};
          f_status = ST_FETCH;
          f_stamp  = write_counter;
        end
      end
      OP_SET: begin
        if (conflict && found) begin
          f_wcinc  = 1'b1;
          f_vwe    = 1'b1;
          f_vidx   = vr_idx;
          f_ventry = '{addr: cur_addr, data: cur_data, stamp: wc_next};
          f_status = ST_RESERVE;
          f_data   = cur_data;
          f_stamp  = wc_next;
        end else if (need_move && vfull) begin
          f_status = ST_RFULL;
        end else if (need_log && lfull) begin
          f_status = ST_LFULL;
        end else begin
          f_vwe    = need_move;
          f_vinc   = need_move;
          f_logwe  = need_log;
          f_wcinc  = 1'b1;
          f_lwe    = 1'b1;
          f_lword  = '{valid: 1'b1, dirty: 1'b1, page: cur_pg, stamp: wc_next,
                       data: cur_data};
          f_status = ST_LINE;
          f_data   = cur_data;
          f_stamp  = wc_next;
        end
      end
      OP_FILL: begin
        if (hit && !lq.dirty) begin
          f_lwe        = 1'b1;
          f_lword.data = cur_data;
          f_status     = ST_FILLED;
          f_data       = cur_data;
          f_stamp      = lq.stamp;
        end
      end
      default: begin
        if (cmt_empty) begin
          f_addr  = '0;
          f_last  = 1'b1;
          f_empty = 1'b1;
        end else begin
          f_drain = 1'b1;
          if (hit) begin
            f_lwe         = 1'b1;
            f_lword.dirty = 1'b0;
            f_status      = ST_WB;
            f_data        = lq.data;
            f_stamp       = lq.stamp;
          end else if (found) begin
            f_status = ST_WB;
            f_data   = vr.entry.data;
            f_stamp  = vr.entry.stamp;
          end
          f_last  = (drain_index + LCNT_W'(1)) >= log_count;
          f_empty = f_last;
        end
      end
    endcase
  end

  assign lwe     = (state == S_CLEAR) || ((state == S_FINISH) && out_free && f_lwe);
  assign lw_idx  = (state == S_CLEAR) ? clr_idx : cur_off;
  assign lw_word = (state == S_CLEAR) ? line_t'('0) : f_lword;

  always_ff @(posedge clk) begin
    lq <= lmem[cur_off];
    if (lwe) begin
      lmem[lw_idx] <= lw_word;
    end
  end

  always_ff @(posedge clk) begin
    log_q <= logm[drain_index[LIDX_W-1:0]];
    if ((state == S_FINISH) && out_free && f_logwe) begin
      logm[log_count[LIDX_W-1:0]] <= cur_addr;
    end
  end

  assign vreq.start = (state == S_LCHK) && need_srch;
  assign vreq.key   = cur_addr;

  bdmc_victim_unit #(
    .DEPTH(VICTIM_DEPTH),
    .IDX_W(VIDX_W),
    .CNT_W(VCNT_W)
  ) u_victim (
    .clk   (clk),
    .rst   (rst),
    .req   (vreq),
    .count (victim_count),
    .we    ((state == S_FINISH) && out_free && f_vwe),
    .widx  (f_vidx),
    .wentry(f_ventry),
    .rsp   (vr),
    .idx   (vr_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      srch          <= 1'b0;
      cmt_empty     <= 1'b0;
      victim_count  <= '0;
      log_count     <= '0;
      drain_index   <= '0;
      write_counter <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !((state == S_FINISH) && out_free)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + OFF_W'(1);
          if (clr_idx == OFF_W'(LINES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cur_op    <= req.op;
            cur_addr  <= req.address;
            cur_data  <= req.write_data;
            srch      <= 1'b0;
            cmt_empty <= 1'b0;
            state     <= (req.op == OP_COMMIT) ? S_LOGRD : S_LREAD;
          end
        end
        S_LOGRD: begin
          if (drain_index >= log_count) begin
            cmt_empty <= 1'b1;
            state     <= S_FINISH;
          end else begin
            cur_addr <= log_q;
            state    <= S_LREAD;
          end
        end
        S_LREAD: begin
          state <= S_LCHK;
        end
        S_LCHK: begin
          if (need_srch) begin
            srch  <= 1'b1;
            state <= S_SEARCH;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SEARCH: begin
          if (vr.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= f_status;
            rsp.read_data   <= f_data;
            rsp.out_address <= f_addr;
            rsp.stamp       <= f_stamp;
            rsp.last        <= f_last;
            if (f_wcinc) begin
              write_counter <= wc_next;
            end
            if (f_empty) begin
              victim_count <= '0;
              log_count    <= '0;
              drain_index  <= '0;
            end else begin
              if (f_vinc) begin
                victim_count <= victim_count + VCNT_W'(1);
              end
              if (f_logwe) begin
                log_count <= log_count + LCNT_W'(1);
              end
              if (f_drain) begin
                drain_index <= drain_index + LCNT_W'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_vcount: assert property (@(posedge clk) disable iff (rst)
    victim_count <= VCNT_W'(VICTIM_DEPTH))
    else $error("victim reserve count beyond depth");

  a_lcount: assert property (@(posedge clk) disable iff (rst)
    log_count <= LCNT_W'(LOG_DEPTH))
    else $error("change log count beyond depth");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    drain_index <= log_count)
    else $error("drain index passed the log count");

  a_search: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && vr.done) |=> (state == S_FINISH))
    else $error("search completion not followed by finish");

endmodule
